// File: rtl/assert_macros.svh
// Assertion helpers; expect clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CWG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be seen out of reset.
`define CWG_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/cwg_pkg.sv
package cwg_pkg;

  localparam int ROWS_DEF = 120;
  localparam int COLS_DEF = 25;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [2:0] REG_SPRING    = 3'd0;
  localparam logic [2:0] REG_ANCHOR    = 3'd1;
  localparam logic [2:0] REG_FRIC      = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_DT        = 3'd4;

  localparam logic [9:0]  SPRING_RST    = 10'd300;
  localparam logic [16:0] ANCHOR_RST    = 17'd1311;
  localparam logic [30:0] FRIC_RST      = 31'd655360;
  localparam logic [30:0] THRESHOLD_RST = 31'd1311;
  localparam logic [16:0] DT_RST        = 17'd655;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_IMPULSE = 2'd1,
    OP_READ    = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef struct packed {
    logic [9:0]  stiffness;
    logic [16:0] anchor_gain;
    logic [30:0] fric_mag;
    logic [30:0] friction_threshold;
    logic [16:0] time_step;
  } cwg_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_IMP_RD,
    ST_IMP_WR,
    ST_RD,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    PH_ISSUE,
    PH_CAPTURE,
    PH_LEFT,
    PH_RIGHT,
    PH_UP,
    PH_DOWN,
    PH_ANCHOR,
    PH_SCALE,
    PH_FRICTION,
    PH_SPLIT,
    PH_WRITE
  } phase_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_FIRST,
    DP_ADDN,
    DP_ANCHOR,
    DP_SCALE,
    DP_FRICTION,
    DP_SPLIT,
    DP_VWRITE,
    DP_P2_CAP,
    DP_PWRITE,
    DP_IMP_WRITE,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   nbr_en;
    logic   in_grid;
    logic   is_read;
    logic   load_imp;
  } cwg_cmd_t;

  localparam logic signed [67:0] S32_MAX = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [67:0] S32_MIN = {{37{1'b1}}, 31'b0};

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/cwg_in_if.sv
interface cwg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [6:0]         row;
  logic [4:0]         col;
  logic signed [31:0] impulse;

  modport source (output valid, operation, row, col, impulse, input ready);
  modport sink (input valid, operation, row, col, impulse, output ready);
endinterface

// File: rtl/cwg_out_if.sv
interface cwg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] cell_position;

  modport source (output valid, kind, cell_position, input ready);
  modport sink (input valid, kind, cell_position, output ready);
endinterface

// File: rtl/cylinder_wave_grid_step.sv
// Mass-spring wave grid on a cylinder, ROWS x COLS cells of Q16.16 position
// and velocity. Requests arrive on in_ch (tick, impulse, read); each request
// except the unused operation code yields one response on out_ch carrying the
// echoed kind and, for a read, the cell position (zero otherwise).
// The user must write registers over the APB port while no request is in flight;
// the block does not enforce this. A tick sweeps the grid twice, a velocity
// pass and then a position pass, one cell at a time. An impulse reads the cell
// velocity and writes it back with the impulse added; a read fetches the cell
// position. The sweep time is set by the single read port of the position memory,
// which fetches one neighbor per cycle, and by the registered multiply chain per cell.
// One request is processed at a time; in_ch.ready is high only when idle.
// The response sits in an output register, so a new request is taken while
// it waits; if the receiver still stalls when the next response is ready,
// the block holds in its done state until out_ch.ready.
// After reset both grids are cleared by a pass over every cell, during
// which in_ch.ready stays low; register writes are taken throughout.
module cylinder_wave_grid_step #(
  parameter int ROWS = cwg_pkg::ROWS_DEF,
  parameter int COLS = cwg_pkg::COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cwg_in_if.sink                        in_ch,
  cwg_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cwg_pkg::APB_AW-1:0]    paddr,
  input  logic [cwg_pkg::APB_DW-1:0]    pwdata,
  output logic [cwg_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  cwg_pkg::cwg_cfg_t             cfg;
  cwg_pkg::cwg_cmd_t             cmd;
  logic [$clog2(ROWS*COLS)-1:0]  addr;

  cwg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cwg_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .operation (in_ch.operation),
    .row       (in_ch.row),
    .col       (in_ch.col),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .cmd       (cmd),
    .addr      (addr)
  );

  cwg_dpath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dpath (
    .clk           (clk),
    .cfg           (cfg),
    .cmd           (cmd),
    .addr          (addr),
    .impulse       (in_ch.impulse),
    .cell_position (out_ch.cell_position)
  );

endmodule

// File: rtl/cwg_regs.sv
module cwg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cwg_pkg::APB_AW-1:0]    paddr,
  input  logic [cwg_pkg::APB_DW-1:0]    pwdata,
  output logic [cwg_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output cwg_pkg::cwg_cfg_t             cfg
);

  cwg_pkg::cwg_cfg_t cfg_r, cfg_nxt;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        cwg_pkg::REG_SPRING:    cfg_nxt.stiffness          = pwdata[9:0];
        cwg_pkg::REG_ANCHOR:    cfg_nxt.anchor_gain        = pwdata[16:0];
        cwg_pkg::REG_FRIC:      cfg_nxt.fric_mag           = pwdata[30:0];
        cwg_pkg::REG_THRESHOLD: cfg_nxt.friction_threshold = pwdata[30:0];
        cwg_pkg::REG_DT:        cfg_nxt.time_step          = pwdata[16:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cwg_pkg::REG_SPRING:    prdata = {22'b0, cfg_r.stiffness};
      cwg_pkg::REG_ANCHOR:    prdata = {15'b0, cfg_r.anchor_gain};
      cwg_pkg::REG_FRIC:      prdata = {1'b0, cfg_r.fric_mag};
      cwg_pkg::REG_THRESHOLD: prdata = {1'b0, cfg_r.friction_threshold};
      cwg_pkg::REG_DT:        prdata = {15'b0, cfg_r.time_step};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness          <= cwg_pkg::SPRING_RST;
      cfg_r.anchor_gain        <= cwg_pkg::ANCHOR_RST;
      cfg_r.fric_mag           <= cwg_pkg::FRIC_RST;
      cfg_r.friction_threshold <= cwg_pkg::THRESHOLD_RST;
      cfg_r.time_step          <= cwg_pkg::DT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/cwg_dpath.sv
module cwg_dpath #(
  parameter int ROWS = cwg_pkg::ROWS_DEF,
  parameter int COLS = cwg_pkg::COLS_DEF
) (
  input  logic                                   clk,
  input  cwg_pkg::cwg_cfg_t                      cfg,
  input  cwg_pkg::cwg_cmd_t                      cmd,
  input  logic [$clog2(ROWS*COLS)-1:0]           addr,
  input  logic signed [31:0]                     impulse,
  output logic signed [31:0]                     cell_position
);

  localparam int CELLS = ROWS * COLS;

  logic signed [31:0] pos_mem [CELLS];
  logic signed [31:0] vel_mem [CELLS];

  logic signed [31:0] pos_rd_r, vel_rd_r;
  logic signed [31:0] p_r, v_r, imp_r, out_r;
  logic signed [49:0] prod_r;
  logic signed [36:0] delta_r;
  logic signed [48:0] force_r;
  logic        [40:0] lo_r;
  logic signed [42:0] hi_r;

  logic               pos_we, vel_we;
  logic signed [31:0] pos_wd, vel_wd;

  logic signed [17:0] ag_s, dt_s;
  logic signed [10:0] k_s;
  logic signed [36:0] diff;
  logic signed [47:0] scaled;
  logic signed [48:0] ff_s;
  logic signed [32:0] neg_thr;
  logic               v_gt, v_lt;
  logic        [40:0] lo_w;
  logic signed [42:0] hi_w;
  logic signed [67:0] vsum, vstep;
  logic signed [31:0] v_new, p_new, v_imp;

  assign ag_s    = {1'b0, cfg.anchor_gain};
  assign dt_s    = {1'b0, cfg.time_step};
  assign k_s     = {1'b0, cfg.stiffness};
  assign ff_s    = {18'b0, cfg.fric_mag};
  assign neg_thr = -$signed({2'b00, cfg.friction_threshold});
  assign v_gt    = v_r > $signed({1'b0, cfg.friction_threshold});
  assign v_lt    = 33'(v_r) < neg_thr;

  assign diff   = 37'(pos_rd_r) - 37'(p_r);
  assign scaled = delta_r * k_s;
  assign lo_w   = force_r[23:0] * cfg.time_step;
  assign hi_w   = $signed(force_r[48:24]) * dt_s;

  // force*dt rebuilt from the two partial products, then floored by 2^16
  assign vsum  = (68'(hi_r) <<< 24) + 68'(lo_r);
  assign vstep = vsum >>> 16;
  assign v_new = cwg_pkg::sat32(68'(v_r) + vstep);
  assign p_new = cwg_pkg::sat32(68'(p_r) + 68'(prod_r >>> 16));
  assign v_imp = cwg_pkg::sat32(68'(vel_rd_r) + 68'(imp_r));

  always_comb begin
    pos_we = 1'b0;
    vel_we = 1'b0;
    pos_wd = '0;
    vel_wd = '0;
    case (cmd.op)
      cwg_pkg::DP_CLEAR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
      end
      cwg_pkg::DP_VWRITE: begin
        vel_we = 1'b1;
        vel_wd = v_new;
      end
      cwg_pkg::DP_PWRITE: begin
        pos_we = 1'b1;
        pos_wd = p_new;
      end
      cwg_pkg::DP_IMP_WRITE: begin
        vel_we = cmd.in_grid;
        vel_wd = v_imp;
      end
      default: begin
        pos_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[addr] <= pos_wd;
    end
    pos_rd_r <= pos_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_mem[addr] <= vel_wd;
    end
    vel_rd_r <= vel_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imp) begin
      imp_r <= impulse;
    end
    case (cmd.op)
      cwg_pkg::DP_CAPTURE: begin
        p_r    <= pos_rd_r;
        v_r    <= vel_rd_r;
        prod_r <= pos_rd_r * ag_s;
      end
      cwg_pkg::DP_FIRST:  delta_r <= diff;
      cwg_pkg::DP_ADDN:   delta_r <= delta_r + (cmd.nbr_en ? diff : 37'sd0);
      cwg_pkg::DP_ANCHOR: delta_r <= delta_r - 37'(prod_r >>> 16);
      cwg_pkg::DP_SCALE:  force_r <= 49'(scaled);
      cwg_pkg::DP_FRICTION: begin
        if (v_gt) begin
          force_r <= force_r - ff_s;
        end else if (v_lt) begin
          force_r <= force_r + ff_s;
        end
      end
      cwg_pkg::DP_SPLIT: begin
        lo_r <= lo_w;
        hi_r <= hi_w;
      end
      cwg_pkg::DP_P2_CAP: begin
        p_r    <= pos_rd_r;
        prod_r <= vel_rd_r * dt_s;
      end
      cwg_pkg::DP_OUT_LOAD: out_r <= (cmd.is_read && cmd.in_grid) ? pos_rd_r : 32'sd0;
      default: begin
        out_r <= out_r;
      end
    endcase
  end

  assign cell_position = out_r;

endmodule

// File: rtl/cwg_ctrl.sv
`include "assert_macros.svh"

module cwg_ctrl #(
  parameter int ROWS = cwg_pkg::ROWS_DEF,
  parameter int COLS = cwg_pkg::COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [6:0]                   row,
  input  logic [4:0]                   col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output cwg_pkg::cwg_cmd_t            cmd,
  output logic [$clog2(ROWS*COLS)-1:0] addr
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  cwg_pkg::state_t state_r, state_nxt;
  cwg_pkg::phase_t ph_r, ph_nxt;
  cwg_pkg::op_t    op_r, op_nxt, kind_r, kind_nxt;
  logic [AW-1:0]   cell_r, cell_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic            in_grid_r, in_grid_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [AW-1:0]   left_a, right_a, up_a, dn_a, req_cell;
  logic            up_en, dn_en, last_cell, last_col, out_free, req_in_grid;

  assign last_cell = cell_r == AW'(CELLS - 1);
  assign last_col  = col_r == CW'(COLS - 1);
  assign up_en     = row_r != '0;
  assign dn_en     = row_r != RW'(ROWS - 1);
  assign left_a    = (col_r == '0) ? cell_r + AW'(COLS - 1) : cell_r - AW'(1);
  assign right_a   = last_col ? cell_r - AW'(COLS - 1) : cell_r + AW'(1);
  assign up_a      = up_en ? cell_r - AW'(COLS) : cell_r;
  assign dn_a      = dn_en ? cell_r + AW'(COLS) : cell_r;
  assign out_free  = !out_valid_r || out_ready;

  assign req_in_grid = (32'(row) < ROWS) && (32'(col) < COLS);
  assign req_cell    = AW'(32'(row) * COLS + 32'(col));

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    op_nxt        = op_r;
    kind_nxt      = kind_r;
    cell_nxt      = cell_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    in_grid_nxt   = in_grid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    addr          = cell_r;
    cmd.op        = cwg_pkg::DP_NOP;
    cmd.nbr_en    = 1'b0;
    cmd.in_grid   = in_grid_r;
    cmd.is_read   = op_r == cwg_pkg::OP_READ;
    cmd.load_imp  = 1'b0;

    case (state_r)
      cwg_pkg::ST_CLEAR: begin
        cmd.op = cwg_pkg::DP_CLEAR;
        if (last_cell) begin
          cell_nxt  = '0;
          state_nxt = cwg_pkg::ST_IDLE;
        end else begin
          cell_nxt = cell_r + AW'(1);
        end
      end
      cwg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_imp = 1'b1;
          op_nxt       = cwg_pkg::op_t'(operation);
          in_grid_nxt  = req_in_grid;
          case (cwg_pkg::op_t'(operation))
            cwg_pkg::OP_TICK: begin
              cell_nxt  = '0;
              row_nxt   = '0;
              col_nxt   = '0;
              ph_nxt    = cwg_pkg::PH_ISSUE;
              state_nxt = cwg_pkg::ST_PASS1;
            end
            cwg_pkg::OP_IMPULSE: begin
              cell_nxt  = req_cell;
              state_nxt = cwg_pkg::ST_IMP_RD;
            end
            cwg_pkg::OP_READ: begin
              cell_nxt  = req_cell;
              state_nxt = cwg_pkg::ST_RD;
            end
            default: begin
              state_nxt = cwg_pkg::ST_IDLE;
            end
          endcase
        end
      end
      cwg_pkg::ST_PASS1: begin
        // one neighbor read per phase; the read data is registered and used by the phase after
        case (ph_r)
          cwg_pkg::PH_ISSUE: ph_nxt = cwg_pkg::PH_CAPTURE;
          cwg_pkg::PH_CAPTURE: begin
            addr   = left_a;
            cmd.op = cwg_pkg::DP_CAPTURE;
            ph_nxt = cwg_pkg::PH_LEFT;
          end
          cwg_pkg::PH_LEFT: begin
            addr   = right_a;
            cmd.op = cwg_pkg::DP_FIRST;
            ph_nxt = cwg_pkg::PH_RIGHT;
          end
          cwg_pkg::PH_RIGHT: begin
            addr       = up_a;
            cmd.op     = cwg_pkg::DP_ADDN;
            cmd.nbr_en = 1'b1;
            ph_nxt     = cwg_pkg::PH_UP;
          end
          cwg_pkg::PH_UP: begin
            addr       = dn_a;
            cmd.op     = cwg_pkg::DP_ADDN;
            cmd.nbr_en = up_en;
            ph_nxt     = cwg_pkg::PH_DOWN;
          end
          cwg_pkg::PH_DOWN: begin
            cmd.op     = cwg_pkg::DP_ADDN;
            cmd.nbr_en = dn_en;
            ph_nxt     = cwg_pkg::PH_ANCHOR;
          end
          cwg_pkg::PH_ANCHOR: begin
            cmd.op = cwg_pkg::DP_ANCHOR;
            ph_nxt = cwg_pkg::PH_SCALE;
          end
          cwg_pkg::PH_SCALE: begin
            cmd.op = cwg_pkg::DP_SCALE;
            ph_nxt = cwg_pkg::PH_FRICTION;
          end
          cwg_pkg::PH_FRICTION: begin
            cmd.op = cwg_pkg::DP_FRICTION;
            ph_nxt = cwg_pkg::PH_SPLIT;
          end
          cwg_pkg::PH_SPLIT: begin
            cmd.op = cwg_pkg::DP_SPLIT;
            ph_nxt = cwg_pkg::PH_WRITE;
          end
          default: begin
            cmd.op = cwg_pkg::DP_VWRITE;
            ph_nxt = cwg_pkg::PH_ISSUE;
            if (last_cell) begin
              cell_nxt  = '0;
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = cwg_pkg::ST_PASS2;
            end else begin
              cell_nxt = cell_r + AW'(1);
              col_nxt  = last_col ? '0 : col_r + CW'(1);
              row_nxt  = last_col ? row_r + RW'(1) : row_r;
            end
          end
        endcase
      end
      cwg_pkg::ST_PASS2: begin
        case (ph_r)
          cwg_pkg::PH_ISSUE: ph_nxt = cwg_pkg::PH_CAPTURE;
          cwg_pkg::PH_CAPTURE: begin
            cmd.op = cwg_pkg::DP_P2_CAP;
            ph_nxt = cwg_pkg::PH_WRITE;
          end
          default: begin
            cmd.op = cwg_pkg::DP_PWRITE;
            ph_nxt = cwg_pkg::PH_ISSUE;
            if (last_cell) begin
              cell_nxt  = '0;
              state_nxt = cwg_pkg::ST_DONE;
            end else begin
              cell_nxt = cell_r + AW'(1);
            end
          end
        endcase
      end
      cwg_pkg::ST_IMP_RD: state_nxt = cwg_pkg::ST_IMP_WR;
      cwg_pkg::ST_IMP_WR: begin
        cmd.op    = cwg_pkg::DP_IMP_WRITE;
        state_nxt = cwg_pkg::ST_DONE;
      end
      cwg_pkg::ST_RD: state_nxt = cwg_pkg::ST_DONE;
      cwg_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op        = cwg_pkg::DP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          kind_nxt      = op_r;
          state_nxt     = cwg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cwg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cwg_pkg::ST_CLEAR;
      ph_r        <= cwg_pkg::PH_ISSUE;
      op_r        <= cwg_pkg::OP_TICK;
      kind_r      <= cwg_pkg::OP_TICK;
      cell_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      in_grid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      op_r        <= op_nxt;
      kind_r      <= kind_nxt;
      cell_r      <= cell_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      in_grid_r   <= in_grid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CWG_NEVER(a_cell_range, (32'(cell_r) >= CELLS) && (state_r == cwg_pkg::ST_PASS1 || state_r == cwg_pkg::ST_PASS2 || state_r == cwg_pkg::ST_CLEAR))
  `CWG_ASSERT(a_done_load, state_r == cwg_pkg::ST_DONE && out_free |=> out_valid_r && state_r == cwg_pkg::ST_IDLE)
  `CWG_ASSERT(a_tick_start, state_r == cwg_pkg::ST_IDLE && in_valid && operation == 2'(cwg_pkg::OP_TICK) |=> state_r == cwg_pkg::ST_PASS1 && cell_r == '0)
  `CWG_NEVER(a_no_pos_wr_pass1, state_r == cwg_pkg::ST_PASS1 && cmd.op == cwg_pkg::DP_PWRITE)

endmodule

// File: tb/cylinder_wave_grid_step_tb.sv
`timescale 1ns / 100ps

module cylinder_wave_grid_step_tb;
  import cwg_pkg::*;

  localparam int NROWS = ROWS_DEF;
  localparam int NCOLS = COLS_DEF;
  localparam int NCELLS = NROWS * NCOLS;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    op_t                kind;
    logic signed [31:0] cell_position;
  } grid_resp_t;

  class grid_scoreboard;
    logic signed [31:0] pos_grid[NCELLS];
    logic signed [31:0] vel_grid[NCELLS];
    logic signed [31:0] next_vel[NCELLS];
    bit [9:0]  spring;
    bit [16:0] anchor;
    bit [30:0] fric;
    bit [30:0] thresh;
    bit [16:0] dt;
    grid_resp_t pending[$];
    int mismatches;

    function new();
      foreach (pos_grid[i]) begin
        pos_grid[i] = '0;
        vel_grid[i] = '0;
      end
      spring = SPRING_RST;
      anchor = ANCHOR_RST;
      fric = FRIC_RST;
      thresh = THRESHOLD_RST;
      dt = DT_RST;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_SPRING:    spring = value[9:0];
        REG_ANCHOR:    anchor = value[16:0];
        REG_FRIC:      fric = value[30:0];
        REG_THRESHOLD: thresh = value[30:0];
        REG_DT:        dt = value[16:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    function void advance_tick();
      longint p, v, delta, force_q, step, thr;
      int idx;
      step = longint'(dt);
      thr = longint'(thresh);
      for (int r = 0; r < NROWS; r++) begin
        for (int c = 0; c < NCOLS; c++) begin
          idx = r * NCOLS + c;
          p = pos_grid[idx];
          v = vel_grid[idx];
          delta = (longint'(pos_grid[r * NCOLS + (c + 1) % NCOLS]) - p)
                + (longint'(pos_grid[r * NCOLS + (c + NCOLS - 1) % NCOLS]) - p);
          if (r > 0) delta += longint'(pos_grid[idx - NCOLS]) - p;
          if (r < NROWS - 1) delta += longint'(pos_grid[idx + NCOLS]) - p;
          delta -= (p * longint'(anchor)) >>> 16;
          force_q = longint'(spring) * delta;
          if (v > thr) force_q -= longint'(fric);
          else if (v < -thr) force_q += longint'(fric);
          next_vel[idx] = clamp32(v + ((force_q * step) >>> 16));
        end
      end
      for (int i = 0; i < NCELLS; i++) begin
        vel_grid[i] = next_vel[i];
        pos_grid[i] = clamp32(longint'(pos_grid[i])
                              + ((longint'(next_vel[i]) * step) >>> 16));
      end
    endfunction

    function void note_request(op_t op, logic [6:0] row, logic [4:0] col,
                               logic signed [31:0] imp);
      grid_resp_t e;
      bit in_grid;
      int idx;
      in_grid = (row < NROWS) && (col < NCOLS);
      idx = int'(row) * NCOLS + int'(col);
      e.kind = op;
      e.cell_position = '0;
      case (op)
        OP_TICK: advance_tick();
        OP_IMPULSE: if (in_grid) vel_grid[idx] = clamp32(longint'(vel_grid[idx]) + longint'(imp));
        OP_READ: if (in_grid) e.cell_position = pos_grid[idx];
        default: return;
      endcase
      pending.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_response(logic [1:0] kind, logic signed [31:0] cell_pos);
      grid_resp_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected response kind %0d pos %0d", kind, cell_pos));
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
      if (cell_pos !== e.cell_position)
        report_mismatch($sformatf("cell_position %0d, want %0d", cell_pos, e.cell_position));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  cwg_in_if in_if();
  cwg_out_if out_if();

  cylinder_wave_grid_step u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  grid_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_response(out_if.kind, out_if.cell_position);
  end

  task send_request(op_t op, logic [6:0] row, logic [4:0] col, logic signed [31:0] imp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.row <= row;
    in_if.col <= col;
    in_if.impulse <= imp;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(op, row, col, imp);
  endtask

  task write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    in_if.valid <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain responses; unused ops give none, so allow a short settle afterward.
  task wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task random_requests(int count);
    op_t op;
    logic [6:0] row;
    logic [4:0] col;
    logic signed [31:0] imp;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 9) op = OP_TICK;
      else if (sel < 55) op = OP_IMPULSE;
      else if (sel < 96) op = OP_READ;
      else op = OP_UNUSED;
      if ($urandom_range(99) < 85) begin
        row = 7'($urandom_range(NROWS - 1));
        col = 5'($urandom_range(NCOLS - 1));
      end else begin
        row = 7'($urandom_range(127));
        col = 5'($urandom_range(31));
      end
      if ($urandom_range(1)) imp = $urandom;
      else imp = $signed($urandom_range(2 * 2097152)) - 32'sd2097152;
      send_request(op, row, col, imp);
    end
  endtask

  task write_config(logic [31:0] k, logic [31:0] a, logic [31:0] f, logic [31:0] t,
                    logic [31:0] d);
    write_reg(REG_SPRING, k);
    write_reg(REG_ANCHOR, a);
    write_reg(REG_FRIC, f);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_DT, d);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.operation = OP_TICK;
    in_if.row = '0;
    in_if.col = '0;
    in_if.impulse = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset configuration
    send_request(OP_READ, 7'd0, 5'd0, 32'sd0);
    send_request(OP_IMPULSE, 7'd0, 5'd0, 32'sh7FFF_FFFF);
    send_request(OP_IMPULSE, 7'd0, 5'd0, 32'sh7FFF_FFFF);
    send_request(OP_IMPULSE, 7'd119, 5'd24, 32'sh8000_0000);
    send_request(OP_IMPULSE, 7'd119, 5'd24, 32'sh8000_0000);
    send_request(OP_IMPULSE, 7'd60, 5'd12, 32'sh0001_0000);
    send_request(OP_IMPULSE, 7'd127, 5'd31, 32'sh0FFF_FFFF);
    send_request(OP_IMPULSE, 7'd120, 5'd0, 32'sh0000_1000);
    send_request(OP_IMPULSE, 7'd0, 5'd25, 32'sh0000_1000);
    send_request(OP_UNUSED, 7'd5, 5'd5, 32'sh1234_5678);
    send_request(OP_TICK, 7'h7F, 5'h1F, 32'shFFFF_FFFF);
    send_request(OP_READ, 7'd0, 5'd0, 32'sd0);
    send_request(OP_READ, 7'd0, 5'd24, 32'sd0);
    send_request(OP_READ, 7'd119, 5'd24, 32'sd0);
    send_request(OP_READ, 7'd60, 5'd12, 32'sd0);
    send_request(OP_READ, 7'd120, 5'd3, 32'sd0);
    send_request(OP_READ, 7'd3, 5'd25, 32'sd0);
    send_request(OP_READ, 7'd127, 5'd31, 32'sd0);
    send_request(OP_TICK, 7'd0, 5'd0, 32'sd0);
    send_request(OP_READ, 7'd1, 5'd0, 32'sd0);
    send_request(OP_READ, 7'd118, 5'd24, 32'sd0);
    random_requests(10);
    wait_drained();

    for (int ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: write_config(32'd1023, 32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536);
        2: write_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        3: write_config($urandom_range(1023), $urandom_range(65536), $urandom & 32'h7FFF_FFFF,
                        $urandom & 32'h7FFF_FFFF, $urandom_range(65536));
        default: write_config($urandom_range(400), $urandom_range(4000),
                              $urandom_range(2000000), $urandom_range(4000),
                              $urandom_range(2000));
      endcase
      send_idle_pct = (ph == 2) ? 48 : (ph == 4) ? 36 : 0;
      recv_stall_pct = (ph == 3) ? 48 : (ph == 4) ? 36 : 0;
      random_requests(20);
      wait_drained();
    end

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/cwg_pkg.sv
rtl/cwg_in_if.sv
rtl/cwg_out_if.sv
rtl/cwg_regs.sv
rtl/cwg_dpath.sv
rtl/cwg_ctrl.sv
rtl/cylinder_wave_grid_step.sv
tb/cylinder_wave_grid_step_tb.sv
